// File: sv/svtu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// svtu_pkg
// Shared constants, codes and control types of the subscale velocity time
// update unit.
// ============================================================================
package svtu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 32;
    localparam int MAX_DIMS   = 3;
    localparam int ENTRIES    = MAX_DIMS * MAX_POINTS;
    localparam int ADDR_W     = $clog2(ENTRIES);

    localparam int WORD_W  = 32;
    localparam int DIR_W   = 2;
    localparam int PT_W    = 5;
    localparam int ND_W    = 2;
    localparam int NP_W    = 6;
    localparam int ALPHA_W = 17;
    localparam int IGD_W   = 31;
    localparam int OPND_W  = WORD_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = PROD_W + 1;

    // input and output stream layout
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 64;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_F      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA_DT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_RATIO  = 3'd4;

    localparam logic [ND_W-1:0]    RST_NUM_DIMS     = 2'd3;
    localparam logic [NP_W-1:0]    RST_NUM_POINTS   = 6'd8;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_F      = 17'd65536;
    localparam logic [IGD_W-1:0]   RST_INV_GAMMA_DT = 31'd65536;
    localparam logic [WORD_W-1:0]  RST_GAMMA_RATIO  = 32'd65536;

    // 1.0 in the fixed-point format, as a multiplier operand
    localparam logic signed [OPND_W-1:0] ONE_FIX = OPND_W'(1) << FRAC_BITS;

    // product terms fed to the shared multiplier
    localparam int TERM_W = 3;
    localparam logic [TERM_W-1:0] TERM_F_OLD = 3'd0; // factor_old * old
    localparam logic [TERM_W-1:0] TERM_F_ACC = 3'd1; // factor_acc * acc
    localparam logic [TERM_W-1:0] TERM_F_RES = 3'd2; // -factor_res * residual
    localparam logic [TERM_W-1:0] TERM_B_NEW = 3'd3; // alpha_f * new
    localparam logic [TERM_W-1:0] TERM_B_OLD = 3'd4; // (1 - alpha_f) * old
    localparam logic [TERM_W-1:0] TERM_C_NEW = 3'd5; // new * inv_gamma_dt
    localparam logic [TERM_W-1:0] TERM_C_OLD = 3'd6; // -old * inv_gamma_dt
    localparam logic [TERM_W-1:0] TERM_C_ACC = 3'd7; // -acc * gamma_ratio

    typedef enum logic [1:0] {
        PH_NV  = 2'd0,
        PH_BV  = 2'd1,
        PH_ACC = 2'd2
    } phase_t;

    typedef struct packed {
        logic [ND_W-1:0]    num_dims;
        logic [NP_W-1:0]    num_points;
        logic [ALPHA_W-1:0] alpha_f;
        logic [IGD_W-1:0]   inv_gamma_dt;
        logic [WORD_W-1:0]  gamma_ratio;
        logic               clear;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic              rd_en;
        logic              mul_en;
        logic [TERM_W-1:0] term;
        logic              acc_en;
        logic              acc_first;
        logic              round_en;
        phase_t            round_kind;
        logic              sweep_adv;
        logic              out_load;
        logic              out_zero;
    } cmd_t;

    typedef struct packed {
        logic in_commit;
        logic in_go;
        logic sweep_last;
        logic out_hold;
    } sts_t;

endpackage

// File: sv/svtu_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// svtu_ctrl
// Sequencer: fetches an entry, steps the shared multiplier through the terms
// of each sum, rounds, and walks the store during a commit sweep.
// ============================================================================
module svtu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  svtu_pkg::sts_t sts,
    output svtu_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_MAC    = 5'b00100,
        ST_ROUND  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    svtu_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]        t_reg, t_next;
    logic              zero_reg, zero_next;

    logic [1:0]                  nterms;
    logic [svtu_pkg::TERM_W-1:0] base;

    always_comb
    begin
        unique case (phase_reg)
            svtu_pkg::PH_NV:
            begin
                base   = svtu_pkg::TERM_F_OLD;
                nterms = 2'd3;
            end
            svtu_pkg::PH_BV:
            begin
                base   = svtu_pkg::TERM_B_NEW;
                nterms = 2'd2;
            end
            default:
            begin
                base   = svtu_pkg::TERM_C_NEW;
                nterms = 2'd3;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        t_next     = t_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        cmd.term       = base + svtu_pkg::TERM_W'(t_reg);
        cmd.round_kind = phase_reg;
        cmd.out_zero   = zero_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start = 1'b1;
                    zero_next = sts.in_commit || !sts.in_go;
                    priority if (!sts.in_go)
                        state_next = ST_FINISH;
                    else if (sts.in_commit)
                    begin
                        phase_next = svtu_pkg::PH_ACC;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        phase_next = svtu_pkg::PH_NV;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                t_next     = 2'd0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // multiply term t while accumulating term t-1
                cmd.mul_en    = (t_reg < nterms);
                cmd.acc_en    = (t_reg != 2'd0);
                cmd.acc_first = (t_reg == 2'd1);
                if (t_reg == nterms)
                    state_next = ST_ROUND;
                else
                    t_next = t_reg + 2'd1;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                unique case (phase_reg)
                    svtu_pkg::PH_NV:
                    begin
                        phase_next = svtu_pkg::PH_BV;
                        t_next     = 2'd0;
                        state_next = ST_MAC;
                    end
                    svtu_pkg::PH_BV:
                        state_next = ST_FINISH;
                    default:
                    begin
                        cmd.sweep_adv = 1'b1;
                        state_next    = sts.sweep_last ? ST_FINISH : ST_FETCH;
                    end
                endcase
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!sts.out_hold)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= svtu_pkg::PH_NV;
            t_reg     <= 2'd0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            t_reg     <= t_next;
            zero_reg  <= zero_next;
        end
    end

    a_blend_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && phase_reg == svtu_pkg::PH_BV) |=> state_reg == ST_FINISH)
        else $error("blend rounding not followed by result hand-off");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_hold)
        else $error("output register overwritten while still held");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> t_reg <= nterms)
        else $error("term counter ran past the sum");

endmodule

// File: sv/svtu_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// svtu_dpath
// Datapath: entry store with valid bits, shared multiplier, accumulator,
// rounding and saturation, sweep address counters and output register.
// ============================================================================
module svtu_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  svtu_pkg::cfg_t                      cfg,
    input  svtu_pkg::cmd_t                      cmd,
    output svtu_pkg::sts_t                      sts,
    input  logic [svtu_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [svtu_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser
);

    localparam int W  = svtu_pkg::WORD_W;
    localparam int AW = svtu_pkg::ADDR_W;

    localparam logic signed [svtu_pkg::ACC_W-1:0] RND_HALF =
        svtu_pkg::ACC_W'(1) << (svtu_pkg::FRAC_BITS - 1);
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // input fields
    logic                        in_action;
    logic [svtu_pkg::DIR_W-1:0]  in_dir;
    logic [svtu_pkg::PT_W-1:0]   in_pt;

    assign in_action = s_tuser[0];
    assign in_dir    = s_tdata[1:0];
    assign in_pt     = s_tdata[6:2];

    // latched item
    logic                        cmt_reg;
    logic [svtu_pkg::DIR_W-1:0]  dir_reg;
    logic [svtu_pkg::PT_W-1:0]   pt_reg;
    logic [W-1:0]                f_old_reg, f_acc_reg, f_res_reg, res_reg;

    // active geometry
    logic [svtu_pkg::ND_W-1:0] nd;
    logic [svtu_pkg::NP_W-1:0] np;

    assign nd = (cfg.num_dims > svtu_pkg::ND_W'(svtu_pkg::MAX_DIMS))
                ? svtu_pkg::ND_W'(svtu_pkg::MAX_DIMS) : cfg.num_dims;
    assign np = (cfg.num_points > svtu_pkg::NP_W'(svtu_pkg::MAX_POINTS))
                ? svtu_pkg::NP_W'(svtu_pkg::MAX_POINTS) : cfg.num_points;

    // sweep counters
    logic [svtu_pkg::DIR_W-1:0] swd_reg;
    logic [svtu_pkg::PT_W-1:0]  swp_reg;
    logic                       swp_wrap;
    logic                       swd_last;

    assign swp_wrap = (svtu_pkg::NP_W'(swp_reg) + svtu_pkg::NP_W'(1)) == np;
    assign swd_last = ({1'b0, swd_reg} + 3'd1) == {1'b0, nd};

    assign sts.in_commit  = in_action;
    assign sts.in_go      = in_action ? (nd != '0 && np != '0)
                                      : (in_dir < nd && svtu_pkg::NP_W'(in_pt) < np);
    assign sts.sweep_last = swd_last && swp_wrap;

    // store address: the same entry is read and then written back
    logic [AW-1:0] upd_addr, sweep_addr, mem_addr;

    assign upd_addr   = AW'(dir_reg) * AW'(svtu_pkg::MAX_POINTS) + AW'(pt_reg);
    assign sweep_addr = AW'(swd_reg) * AW'(svtu_pkg::MAX_POINTS) + AW'(swp_reg);
    assign mem_addr   = cmt_reg ? sweep_addr : upd_addr;

    // entry store: {acceleration, new velocity, old velocity}
    logic [3*W-1:0]                 mem [svtu_pkg::ENTRIES];
    logic [3*W-1:0]                 rd_data_reg;
    logic                           rd_valid_reg;
    logic [svtu_pkg::ENTRIES-1:0]   valid_reg;
    logic                           mem_we;
    logic [3*W-1:0]                 wr_data;

    logic [W-1:0] old_eff, new_eff, acc_eff;

    assign old_eff = rd_valid_reg ? rd_data_reg[W-1:0]     : '0;
    assign new_eff = rd_valid_reg ? rd_data_reg[2*W-1:W]   : '0;
    assign acc_eff = rd_valid_reg ? rd_data_reg[3*W-1:2*W] : '0;

    // operand selection
    logic signed [svtu_pkg::OPND_W-1:0] opnd_a, opnd_b;
    logic signed [svtu_pkg::PROD_W-1:0] prod_full;
    logic signed [svtu_pkg::PROD_W-1:0] prod_reg;
    logic signed [svtu_pkg::ACC_W-1:0]  acc_reg;
    logic [W-1:0]                       nv_reg, bv_reg;

    always_comb
    begin
        unique case (cmd.term)
            svtu_pkg::TERM_F_OLD:
            begin
                opnd_a = {f_old_reg[W-1], f_old_reg};
                opnd_b = {old_eff[W-1], old_eff};
            end
            svtu_pkg::TERM_F_ACC:
            begin
                opnd_a = {f_acc_reg[W-1], f_acc_reg};
                opnd_b = {acc_eff[W-1], acc_eff};
            end
            svtu_pkg::TERM_F_RES:
            begin
                opnd_a = -{f_res_reg[W-1], f_res_reg};
                opnd_b = {res_reg[W-1], res_reg};
            end
            svtu_pkg::TERM_B_NEW:
            begin
                opnd_a = {{(svtu_pkg::OPND_W-svtu_pkg::ALPHA_W){1'b0}}, cfg.alpha_f};
                opnd_b = {nv_reg[W-1], nv_reg};
            end
            svtu_pkg::TERM_B_OLD:
            begin
                opnd_a = svtu_pkg::ONE_FIX
                         - {{(svtu_pkg::OPND_W-svtu_pkg::ALPHA_W){1'b0}}, cfg.alpha_f};
                opnd_b = {old_eff[W-1], old_eff};
            end
            svtu_pkg::TERM_C_NEW:
            begin
                opnd_a = {new_eff[W-1], new_eff};
                opnd_b = {{(svtu_pkg::OPND_W-svtu_pkg::IGD_W){1'b0}}, cfg.inv_gamma_dt};
            end
            svtu_pkg::TERM_C_OLD:
            begin
                opnd_a = -{old_eff[W-1], old_eff};
                opnd_b = {{(svtu_pkg::OPND_W-svtu_pkg::IGD_W){1'b0}}, cfg.inv_gamma_dt};
            end
            default:
            begin
                opnd_a = -{acc_eff[W-1], acc_eff};
                opnd_b = {cfg.gamma_ratio[W-1], cfg.gamma_ratio};
            end
        endcase
    end

    assign prod_full = opnd_a * opnd_b;

    // round half up, then saturate to 32 bits
    logic signed [svtu_pkg::ACC_W-1:0] rnd_sum, rnd_shift;
    logic                              ovf_pos, ovf_neg, rnd_sat;
    logic [W-1:0]                      rnd_val;

    assign rnd_sum   = acc_reg + RND_HALF;
    assign rnd_shift = rnd_sum >>> svtu_pkg::FRAC_BITS;
    assign ovf_pos   = !rnd_shift[svtu_pkg::ACC_W-1] && (|rnd_shift[svtu_pkg::ACC_W-2:W-1]);
    assign ovf_neg   = rnd_shift[svtu_pkg::ACC_W-1] && !(&rnd_shift[svtu_pkg::ACC_W-2:W-1]);
    assign rnd_sat   = ovf_pos || ovf_neg;

    always_comb
    begin
        priority if (ovf_pos)
            rnd_val = SAT_MAX;
        else if (ovf_neg)
            rnd_val = SAT_MIN;
        else
            rnd_val = rnd_shift[W-1:0];
    end

    always_comb
    begin
        mem_we  = cmd.round_en && (cmd.round_kind != svtu_pkg::PH_BV);
        if (cmd.round_kind == svtu_pkg::PH_ACC)
            wr_data = {rnd_val, new_eff, new_eff};
        else
            wr_data = {acc_eff, rnd_val, old_eff};
    end

    // store and its read register
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[mem_addr];
    end

    // valid bits: a cleared entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.clear)
                valid_reg <= '0;
            else if (mem_we)
                valid_reg[mem_addr] <= 1'b1;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[mem_addr];
        end
    end

    // item latch, multiplier and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmt_reg   <= in_action;
            dir_reg   <= in_dir;
            pt_reg    <= in_pt;
            f_old_reg <= s_tdata[38:7];
            f_acc_reg <= s_tdata[70:39];
            f_res_reg <= s_tdata[102:71];
            res_reg   <= s_tdata[134:103];
        end
        if (cmd.mul_en)
            prod_reg <= prod_full;
        if (cmd.acc_en)
            acc_reg <= (cmd.acc_first ? '0 : acc_reg)
                       + {prod_reg[svtu_pkg::PROD_W-1], prod_reg};
        if (cmd.round_en && cmd.round_kind == svtu_pkg::PH_NV)
            nv_reg <= rnd_val;
        if (cmd.round_en && cmd.round_kind == svtu_pkg::PH_BV)
            bv_reg <= rnd_val;
    end

    // sweep counters and sticky saturation flag
    logic sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swd_reg <= '0;
            swp_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                swd_reg <= '0;
                swp_reg <= '0;
            end
            else if (cmd.sweep_adv)
            begin
                if (swp_wrap)
                begin
                    swp_reg <= '0;
                    swd_reg <= swd_reg + svtu_pkg::DIR_W'(1);
                end
                else
                    swp_reg <= swp_reg + svtu_pkg::PT_W'(1);
            end

            if (cmd.start)
                sat_reg <= 1'b0;
            else if (cmd.round_en && rnd_sat)
                sat_reg <= 1'b1;
        end
    end

    // output register
    logic         out_valid_reg;
    logic [W-1:0] out_nv_reg, out_bv_reg;
    logic         out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_nv_reg  <= cmd.out_zero ? '0 : nv_reg;
            out_bv_reg  <= cmd.out_zero ? '0 : bv_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign sts.out_hold = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {out_bv_reg, out_nv_reg};
    assign m_tuser      = out_sat_reg;

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> valid_reg == '0)
        else $error("geometry write left entries valid");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !cfg.clear) |=> valid_reg[$past(mem_addr)])
        else $error("written entry not marked valid");

endmodule

// File: sv/subscale_velocity_time_update_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// subscale_velocity_time_update_unit
// Generalized-alpha subscale velocity history: point updates and end-of-step
// commit sweeps over a store of old velocity, new velocity and acceleration.
// ============================================================================
// One item is in work at a time; the next one is taken once the current
// result sits in the output register. A point update on an active entry
// runs one store read, three multiply-accumulate terms, rounding, two
// blend terms, rounding and the hand-off. A point update on an inactive
// entry goes straight to the hand-off. A commit sweep visits every active
// entry in turn: read, three terms plus one step to add the last product,
// and the write-back. The schedule is set by the single shared 33 x 33
// multiplier and the single port of the entry store. The store is cleared
// at once by valid bits on reset and on any write of num_dims or
// num_points; no clearing pass is needed.
// ============================================================================
module subscale_velocity_time_update_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // direction[1:0], point[6:2], factor_old[38:7], factor_acc[70:39],
    // factor_res[102:71], residual[134:103]
    input  logic [svtu_pkg::IN_DATA_W-1:0]      s_tdata,
    // action[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_velocity[31:0], blended_velocity[63:32]
    output logic [svtu_pkg::OUT_DATA_W-1:0]     m_tdata,
    // saturated[0]
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [svtu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [svtu_pkg::CFG_W-1:0]          cfg_data
);

    logic [svtu_pkg::ND_W-1:0]    num_dims_reg;
    logic [svtu_pkg::NP_W-1:0]    num_points_reg;
    logic [svtu_pkg::ALPHA_W-1:0] alpha_f_reg;
    logic [svtu_pkg::IGD_W-1:0]   inv_gamma_dt_reg;
    logic [svtu_pkg::WORD_W-1:0]  gamma_ratio_reg;

    svtu_pkg::cfg_t cfg;
    svtu_pkg::cmd_t cmd;
    svtu_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg     <= svtu_pkg::RST_NUM_DIMS;
            num_points_reg   <= svtu_pkg::RST_NUM_POINTS;
            alpha_f_reg      <= svtu_pkg::RST_ALPHA_F;
            inv_gamma_dt_reg <= svtu_pkg::RST_INV_GAMMA_DT;
            gamma_ratio_reg  <= svtu_pkg::RST_GAMMA_RATIO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svtu_pkg::CFG_NUM_DIMS:
                    num_dims_reg <= cfg_data[svtu_pkg::ND_W-1:0];
                svtu_pkg::CFG_NUM_POINTS:
                    num_points_reg <= cfg_data[svtu_pkg::NP_W-1:0];
                svtu_pkg::CFG_ALPHA_F:
                    alpha_f_reg <= cfg_data[svtu_pkg::ALPHA_W-1:0];
                svtu_pkg::CFG_INV_GAMMA_DT:
                    inv_gamma_dt_reg <= cfg_data[svtu_pkg::IGD_W-1:0];
                svtu_pkg::CFG_GAMMA_RATIO:
                    gamma_ratio_reg <= cfg_data;
                default:
                    ; // drop writes to unknown registers
            endcase
        end
    end

    // any geometry write empties the store, even with an unchanged value
    always_comb
    begin
        cfg.num_dims     = num_dims_reg;
        cfg.num_points   = num_points_reg;
        cfg.alpha_f      = alpha_f_reg;
        cfg.inv_gamma_dt = inv_gamma_dt_reg;
        cfg.gamma_ratio  = gamma_ratio_reg;
        cfg.clear        = cfg_we && (cfg_index == svtu_pkg::CFG_NUM_DIMS
                                      || cfg_index == svtu_pkg::CFG_NUM_POINTS);
    end

    svtu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svtu_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
